// File: sv/quadratic_root_solver_defines.svh
// assertion macros shared by the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication
`define QRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/qrs_pkg.sv
// types and constants of the quadratic root solver
package qrs_pkg;

   localparam int COEF_W      = 32;
   localparam int PROD_W      = 2 * COEF_W;
   localparam int DISC_W      = PROD_W + 2;
   localparam int MAG_W       = DISC_W - 1;
   localparam int ROOT_W      = 33;
   localparam int DEN_W       = COEF_W + 1;
   localparam int FRAC_W      = 16;
   localparam int NUM_W       = ROOT_W + 1;
   localparam int DIVIDEND_W  = NUM_W + FRAC_W;
   localparam int REM_W       = DEN_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_ERROR    = 2'd0,
      KIND_TWO_REAL = 2'd1,
      KIND_DOUBLE   = 2'd2,
      KIND_COMPLEX  = 2'd3
   } root_kind_type;

   typedef struct packed {
      root_kind_type             kind;
      logic signed [COEF_W-1:0]  coef_b;
      logic                      den_neg;
      logic [DEN_W-1:0]          den_mag;
   } job_info_type;

   typedef struct packed {
      job_info_type              info;
      logic [MAG_W-1:0]          disc_mag;
   } queue_entry_type;

endpackage

// File: sv/qrs_if.sv
// request and response channel interfaces
interface qrs_req_if
   import qrs_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coef_a;
   logic signed [COEF_W-1:0] coef_b;
   logic signed [COEF_W-1:0] coef_c;

   modport source  (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink    (input valid, coef_a, coef_b, coef_c, output ready);
   modport monitor (input valid, ready, coef_a, coef_b, coef_c);
endinterface

interface qrs_rsp_if
   import qrs_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [1:0]               root_kind;
   logic signed [COEF_W-1:0] first_value;
   logic signed [COEF_W-1:0] second_value;
   logic                     saturated;

   modport source  (output valid, root_kind, first_value, second_value, saturated, input ready);
   modport sink    (input valid, root_kind, first_value, second_value, saturated, output ready);
   modport monitor (input valid, ready, root_kind, first_value, second_value, saturated);
endinterface

// File: sv/quadratic_root_solver.sv
// top level of the quadratic root solver
//
//   channel   dir  handshake      payload
//   req_if    in   valid/ready    coef_a, coef_b, coef_c (signed Q16.16)
//   rsp_if    out  valid/ready    root_kind, first_value, second_value, saturated
//
// one request per cycle sustained while rsp_if.ready stays high
// pipeline: 2 front stages, the queue, 33 square root stages, 1 numerator stage,
// 50 divider stages and the response register
// synchronous reset clears all valid bits and the queue, no clearing pass
// a stalled response freezes the back pipeline; the 4-entry queue keeps the front going
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver
   import qrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   qrs_req_if.sink     req_if,
   qrs_rsp_if.source   rsp_if
);

   logic            q_in_valid, q_in_ready;
   logic            q_out_valid, q_out_ready;
   queue_entry_type q_in_data, q_out_data;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .job_valid (q_in_valid),
      .job_ready (q_in_ready),
      .job_data  (q_in_data)
   );

   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   qrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_out_valid),
      .job_ready (q_out_ready),
      .job_data  (q_out_data),
      .rsp_if    (rsp_if)
   );

   `QRS_ASSERT_IMPL(a_error_zero, clock, reset, rsp_if.valid && (rsp_if.root_kind == KIND_ERROR), (rsp_if.first_value == '0) && (rsp_if.second_value == '0) && !rsp_if.saturated, "error response carries values")
   `QRS_ASSERT_IMPL(a_double_equal, clock, reset, rsp_if.valid && (rsp_if.root_kind == KIND_DOUBLE), rsp_if.first_value == rsp_if.second_value, "double root values differ")
   `QRS_ASSERT_NEXT(a_front_holds, clock, reset, q_in_valid && !q_in_ready, q_in_valid, "front dropped a request while the queue was full")

endmodule

// File: sv/qrs_queue.sv
// small register queue between the front and back parts
module qrs_queue
   import qrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  queue_entry_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output queue_entry_type out_data
);

   queue_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: sv/qrs_front.sv
// front part: products, discriminant and classification
module qrs_front
   import qrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   qrs_req_if.sink         req_if,
   output logic            job_valid,
   input  logic            job_ready,
   output queue_entry_type job_data
);

   logic                     adv;

   logic                     s1_v_ff;
   logic signed [PROD_W-1:0] s1_bb_ff, s1_bb_in;
   logic signed [PROD_W-1:0] s1_ac_ff, s1_ac_in;
   logic signed [COEF_W-1:0] s1_b_ff;
   logic                     s1_a_zero_ff, s1_a_zero_in;
   logic                     s1_den_neg_ff;
   logic [DEN_W-1:0]         s1_den_mag_ff, s1_den_mag_in;

   logic                     s2_v_ff;
   queue_entry_type          s2_entry_ff, s2_entry_in;

   logic [COEF_W-1:0]        a_abs;
   logic signed [DISC_W-1:0] bb_ext, ac_ext, d_pos, d_neg;

   assign adv          = !s2_v_ff || job_ready;
   assign req_if.ready = adv;
   assign job_valid    = s2_v_ff;
   assign job_data     = s2_entry_ff;

   always_comb begin
      s1_bb_in      = req_if.coef_b * req_if.coef_b;
      s1_ac_in      = req_if.coef_a * req_if.coef_c;
      s1_a_zero_in  = (req_if.coef_a == '0);
      a_abs         = req_if.coef_a[COEF_W-1] ? ('0 - req_if.coef_a) : req_if.coef_a;
      s1_den_mag_in = {a_abs, 1'b0};
   end

   always_comb begin
      bb_ext = {{(DISC_W - PROD_W){s1_bb_ff[PROD_W-1]}}, s1_bb_ff};
      ac_ext = {s1_ac_ff, 2'b00};
      d_pos  = bb_ext - ac_ext;
      d_neg  = ac_ext - bb_ext;
      s2_entry_in.info.coef_b  = s1_b_ff;
      s2_entry_in.info.den_neg = s1_den_neg_ff;
      s2_entry_in.info.den_mag = s1_den_mag_ff;
      s2_entry_in.disc_mag     = d_pos[DISC_W-1] ? d_neg[MAG_W-1:0] : d_pos[MAG_W-1:0];
      priority if (s1_a_zero_ff) begin
         s2_entry_in.info.kind = KIND_ERROR;
      end else if (d_pos[DISC_W-1]) begin
         s2_entry_in.info.kind = KIND_COMPLEX;
      end else if (d_pos == '0) begin
         s2_entry_in.info.kind = KIND_DOUBLE;
      end else begin
         s2_entry_in.info.kind = KIND_TWO_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_if.valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bb_ff      <= s1_bb_in;
         s1_ac_ff      <= s1_ac_in;
         s1_b_ff       <= req_if.coef_b;
         s1_a_zero_ff  <= s1_a_zero_in;
         s1_den_neg_ff <= req_if.coef_a[COEF_W-1];
         s1_den_mag_ff <= s1_den_mag_in;
         s2_entry_ff   <= s2_entry_in;
      end
   end

endmodule

// File: sv/qrs_back.sv
// back part: pipelined square root, numerators, dividers and clipping
module qrs_back
   import qrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   output logic            job_ready,
   input  queue_entry_type job_data,
   qrs_rsp_if.source       rsp_if
);

   typedef struct packed {
      job_info_type      info;
      logic [MAG_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_stage_type;

   typedef struct packed {
      root_kind_type         kind;
      logic [DEN_W-1:0]      den_mag;
      logic                  first_neg;
      logic                  second_neg;
      logic [DIVIDEND_W-1:0] first_dvd;
      logic [DIVIDEND_W-1:0] second_dvd;
      logic [DEN_W-1:0]      first_rem;
      logic [DEN_W-1:0]      second_rem;
      logic [DIVIDEND_W-1:0] first_quo;
      logic [DIVIDEND_W-1:0] second_quo;
   } div_stage_type;

   logic                     adv;

   logic [ROOT_W-1:0]        sq_v_ff;
   sqrt_stage_type           sq_ff  [ROOT_W];
   sqrt_stage_type           sq_in  [ROOT_W];
   sqrt_stage_type           sq_cur [ROOT_W];

   logic                     nm_v_ff;
   div_stage_type            nm_ff, nm_in;

   logic [DIVIDEND_W-1:0]    dv_v_ff;
   div_stage_type            dv_ff  [DIVIDEND_W];
   div_stage_type            dv_in  [DIVIDEND_W];
   div_stage_type            dv_cur [DIVIDEND_W];

   logic                     rsp_v_ff;
   root_kind_type            rsp_kind_ff, rsp_kind_in;
   logic signed [COEF_W-1:0] rsp_first_ff, rsp_first_in;
   logic signed [COEF_W-1:0] rsp_second_ff, rsp_second_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   function automatic logic [COEF_W:0] clip(input logic neg, input logic [DIVIDEND_W-1:0] q);
      logic              over;
      logic [COEF_W-1:0] v;
      if (neg) begin
         over = (q[DIVIDEND_W-1:COEF_W] != '0) || (q[COEF_W-1] && (q[COEF_W-2:0] != '0));
         v    = over ? {1'b1, {(COEF_W - 1){1'b0}}} : ('0 - q[COEF_W-1:0]);
      end else begin
         over = (q[DIVIDEND_W-1:COEF_W-1] != '0);
         v    = over ? {1'b0, {(COEF_W - 1){1'b1}}} : q[COEF_W-1:0];
      end
      return {over, v};
   endfunction

   assign adv       = !rsp_v_ff || rsp_if.ready;
   assign job_ready = adv;

   // square root, one result bit per stage
   always_comb begin
      logic [MAG_W+1:0] trial;
      sq_cur[0].info = job_data.info;
      sq_cur[0].rem  = job_data.disc_mag;
      sq_cur[0].root = '0;
      for (int i = 1; i < ROOT_W; i++) begin
         sq_cur[i] = sq_ff[i-1];
      end
      for (int i = 0; i < ROOT_W; i++) begin
         trial = ((MAG_W + 2)'(sq_cur[i].root) << (ROOT_W - i))
               | ((MAG_W + 2)'(1) << (2 * (ROOT_W - 1 - i)));
         sq_in[i] = sq_cur[i];
         if (trial <= (MAG_W + 2)'(sq_cur[i].rem)) begin
            sq_in[i].rem  = MAG_W'((MAG_W + 2)'(sq_cur[i].rem) - trial);
            sq_in[i].root = sq_cur[i].root | (ROOT_W'(1) << (ROOT_W - 1 - i));
         end
      end
   end

   // numerators and signs
   always_comb begin
      sqrt_stage_type         last;
      logic signed [NUM_W:0]  neg_b, root_s, first_n, second_n;
      last   = sq_ff[ROOT_W-1];
      neg_b  = '0 - {{(NUM_W + 1 - COEF_W){last.info.coef_b[COEF_W-1]}}, last.info.coef_b};
      root_s = {{(NUM_W + 1 - ROOT_W){1'b0}}, last.root};
      if (last.info.kind == KIND_COMPLEX) begin
         first_n  = neg_b;
         second_n = root_s;
      end else begin
         first_n  = neg_b + root_s;
         second_n = neg_b - root_s;
      end
      nm_in.kind       = last.info.kind;
      nm_in.den_mag    = last.info.den_mag;
      nm_in.first_neg  = first_n[NUM_W] ^ last.info.den_neg;
      nm_in.second_neg = second_n[NUM_W] ^ last.info.den_neg;
      nm_in.first_dvd  = {(first_n[NUM_W] ? NUM_W'('0 - first_n) : first_n[NUM_W-1:0]),
                          {FRAC_W{1'b0}}};
      nm_in.second_dvd = {(second_n[NUM_W] ? NUM_W'('0 - second_n) : second_n[NUM_W-1:0]),
                          {FRAC_W{1'b0}}};
      nm_in.first_rem  = '0;
      nm_in.second_rem = '0;
      nm_in.first_quo  = '0;
      nm_in.second_quo = '0;
   end

   // two restoring dividers, one quotient bit per stage
   always_comb begin
      logic [REM_W-1:0] shifted1, shifted2;
      logic [REM_W-1:0] den_ext;
      dv_cur[0] = nm_ff;
      for (int j = 1; j < DIVIDEND_W; j++) begin
         dv_cur[j] = dv_ff[j-1];
      end
      for (int j = 0; j < DIVIDEND_W; j++) begin
         dv_in[j] = dv_cur[j];
         den_ext  = {1'b0, dv_cur[j].den_mag};
         shifted1 = {dv_cur[j].first_rem, dv_cur[j].first_dvd[DIVIDEND_W-1-j]};
         shifted2 = {dv_cur[j].second_rem, dv_cur[j].second_dvd[DIVIDEND_W-1-j]};
         if (shifted1 >= den_ext) begin
            dv_in[j].first_rem                  = DEN_W'(shifted1 - den_ext);
            dv_in[j].first_quo[DIVIDEND_W-1-j]  = 1'b1;
         end else begin
            dv_in[j].first_rem = shifted1[DEN_W-1:0];
         end
         if (shifted2 >= den_ext) begin
            dv_in[j].second_rem                 = DEN_W'(shifted2 - den_ext);
            dv_in[j].second_quo[DIVIDEND_W-1-j] = 1'b1;
         end else begin
            dv_in[j].second_rem = shifted2[DEN_W-1:0];
         end
      end
   end

   // clipping and error override
   always_comb begin
      div_stage_type     last;
      logic [COEF_W:0]   first_c, second_c;
      last     = dv_ff[DIVIDEND_W-1];
      first_c  = clip(last.first_neg, last.first_quo);
      second_c = clip(last.second_neg, last.second_quo);
      rsp_kind_in = last.kind;
      if (last.kind == KIND_ERROR) begin
         rsp_first_in  = '0;
         rsp_second_in = '0;
         rsp_sat_in    = 1'b0;
      end else begin
         rsp_first_in  = first_c[COEF_W-1:0];
         rsp_second_in = second_c[COEF_W-1:0];
         rsp_sat_in    = first_c[COEF_W] || second_c[COEF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= '0;
         nm_v_ff  <= 1'b0;
         dv_v_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         sq_v_ff  <= {sq_v_ff[ROOT_W-2:0], job_valid};
         nm_v_ff  <= sq_v_ff[ROOT_W-1];
         dv_v_ff  <= {dv_v_ff[DIVIDEND_W-2:0], nm_v_ff};
         rsp_v_ff <= dv_v_ff[DIVIDEND_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff         <= sq_in;
         nm_ff         <= nm_in;
         dv_ff         <= dv_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_first_ff  <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_if.valid        = rsp_v_ff;
   assign rsp_if.root_kind    = rsp_kind_ff;
   assign rsp_if.first_value  = rsp_first_ff;
   assign rsp_if.second_value = rsp_second_ff;
   assign rsp_if.saturated    = rsp_sat_ff;

endmodule
